FILE: hdl/operator_precedence_postfix_assert.svh
// assertion macros for the operator precedence postfix converter
`ifndef OPERATOR_PRECEDENCE_POSTFIX_ASSERT_SVH
`define OPERATOR_PRECEDENCE_POSTFIX_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define OPP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("operator_precedence_postfix: same-cycle check failed");

// next-cycle implication
`define OPP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("operator_precedence_postfix: next-cycle check failed");

`else

`define OPP_ASSERT_IMPL(label, clk, rst, ante, cons)
`define OPP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: hdl/opp_pkg.sv
// shared types, codes and the precedence table of the postfix converter
package opp_pkg;

   // input item modes
   localparam logic [1:0] MODE_OPERAND  = 2'd0;
   localparam logic [1:0] MODE_OPERATOR = 2'd1;
   localparam logic [1:0] MODE_END      = 2'd2;

   // operator codes
   localparam logic [2:0] OP_LT   = 3'd0;
   localparam logic [2:0] OP_ERR  = 3'd1;
   localparam logic [2:0] OP_PIPE = 3'd2;
   localparam logic [2:0] OP_GT   = 3'd3;
   localparam logic [2:0] OP_AND  = 3'd4;
   localparam logic [2:0] OP_OR   = 3'd5;
   localparam logic [2:0] OP_SEMI = 3'd6;
   localparam logic [2:0] OP_NONE = 3'd7;

   localparam int unsigned ID_W = 16;

   typedef enum logic [1:0] {
      KIND_OPERAND  = 2'd0,
      KIND_OPERATOR = 2'd1,
      KIND_END      = 2'd2,
      KIND_OVERFLOW = 2'd3
   } kind_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_POP  = 1'b1
   } state_type;

   // one result transaction handed to the output register
   typedef struct packed {
      logic              load;
      kind_type          kind;
      logic [ID_W-1:0]   operand;
      logic [2:0]        op;
      logic              last;
   } emit_type;

   typedef struct packed {
      logic busy;
   } status_type;

   // precedence level, unknown code ranks above everything
   function automatic logic [2:0] prec_level(input logic [2:0] code);
      logic [2:0] lvl;
      case (code)
         OP_LT, OP_ERR: lvl = 3'd1;
         OP_PIPE:       lvl = 3'd2;
         OP_GT:         lvl = 3'd3;
         OP_AND, OP_OR: lvl = 3'd4;
         OP_SEMI:       lvl = 3'd5;
         default:       lvl = 3'd7;
      endcase
      return lvl;
   endfunction

endpackage

FILE: hdl/opp_stack.sv
// operator stack memory: one write port, two registered read ports
module opp_stack
   import opp_pkg::*;
#(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned AW    = 4
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [2:0]    wr_data,
   input  logic [AW-1:0] rd0_addr,
   input  logic [AW-1:0] rd1_addr,
   output logic [2:0]    rd0_data,
   output logic [2:0]    rd1_data
);

   logic [2:0] mem [DEPTH];
   logic [2:0] rd0_ff;
   logic [2:0] rd1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd0_ff <= mem[rd0_addr];
      rd1_ff <= mem[rd1_addr];
   end

   assign rd0_data = rd0_ff;
   assign rd1_data = rd1_ff;

endmodule

FILE: hdl/opp_seq.sv
// sequencer: accepts tokens, walks the stack top, pushes and flushes
module opp_seq
   import opp_pkg::*;
#(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned AW    = 4,
   parameter int unsigned CW    = 5
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [1:0]      req_mode,
   input  logic [ID_W-1:0] req_operand_id,
   input  logic [2:0]      req_op_code,
   input  logic            out_free,
   output emit_type        emit,
   output status_type      status,
   output logic [CW-1:0]   count,
   output logic            wr_en,
   output logic [AW-1:0]   wr_addr,
   output logic [2:0]      wr_data,
   output logic [AW-1:0]   rd0_addr,
   output logic [AW-1:0]   rd1_addr,
   input  logic [2:0]      rd0_data,
   input  logic [2:0]      rd1_data
);

   localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
   localparam logic [CW-1:0] CNT_ONE  = CW'(1);
   localparam logic [CW-1:0] CNT_TWO  = CW'(2);

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [2:0]    code_ff, code_in;
   logic [2:0]    lvl_ff, lvl_in;
   logic          flush_ff, flush_in;
   logic          accept;
   logic          top_ok;
   logic          more;
   logic [CW-1:0] cnt_m1;
   logic [CW-1:0] cnt_m2;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      code_ff  <= code_in;
      lvl_ff   <= lvl_in;
      flush_ff <= flush_in;
   end

   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;
   assign top_ok    = (count_ff != '0);
   assign more      = (count_ff > CNT_ONE) && (prec_level(rd1_data) <= lvl_ff);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      code_in  = code_ff;
      lvl_in   = lvl_ff;
      flush_in = flush_ff;
      emit     = '0;
      wr_en    = 1'b0;
      wr_addr  = count_ff[AW-1:0];
      wr_data  = code_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_mode)
                  MODE_OPERAND: begin
                     emit.load    = 1'b1;
                     emit.kind    = KIND_OPERAND;
                     emit.operand = req_operand_id;
                     emit.last    = 1'b1;
                  end
                  MODE_OPERATOR: begin
                     if (req_op_code != OP_NONE) begin
                        code_in  = req_op_code;
                        lvl_in   = prec_level(req_op_code);
                        flush_in = 1'b0;
                        state_in = ST_POP;
                     end
                  end
                  MODE_END: begin
                     flush_in = 1'b1;
                     state_in = ST_POP;
                  end
                  default: ;
               endcase
            end
         end
         ST_POP: begin
            if (flush_ff) begin
               if (out_free) begin
                  emit.load = 1'b1;
                  if (top_ok) begin
                     emit.kind = KIND_OPERATOR;
                     emit.op   = rd0_data;
                     count_in  = count_ff - CNT_ONE;
                  end else begin
                     emit.kind = KIND_END;
                     emit.last = 1'b1;
                     state_in  = ST_IDLE;
                  end
               end
            end else if (top_ok && (prec_level(rd0_data) <= lvl_ff)) begin
               if (out_free) begin
                  emit.load = 1'b1;
                  emit.kind = KIND_OPERATOR;
                  emit.op   = rd0_data;
                  emit.last = !more;
                  count_in  = count_ff - CNT_ONE;
                  if (!more) begin
                     // last pop: the new operator takes the freed slot
                     wr_en    = 1'b1;
                     wr_addr  = cnt_m1[AW-1:0];
                     count_in = count_ff;
                     state_in = ST_IDLE;
                  end
               end
            end else if (count_ff == CNT_FULL) begin
               if (out_free) begin
                  emit.load = 1'b1;
                  emit.kind = KIND_OVERFLOW;
                  emit.op   = code_ff;
                  emit.last = 1'b1;
                  state_in  = ST_IDLE;
               end
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CNT_ONE;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign cnt_m1 = count_ff - CNT_ONE;

   // reads always follow the next count, so the stack top is already registered when the next state needs it
   assign cnt_m2   = (count_in >= CNT_TWO) ? (count_in - CNT_TWO) : '0;
   assign rd0_addr = count_in[AW-1:0] - AW'(1);
   assign rd1_addr = cnt_m2[AW-1:0];

   assign status.busy = (state_ff != ST_IDLE);
   assign count       = count_ff;

endmodule

FILE: hdl/opp_out.sv
// result output register
module opp_out
   import opp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  emit_type        emit,
   output logic            out_free,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [1:0]      rsp_kind,
   output logic [ID_W-1:0] rsp_out_operand,
   output logic [2:0]      rsp_out_op,
   output logic            rsp_last
);

   logic            valid_ff;
   kind_type        kind_ff;
   logic [ID_W-1:0] operand_ff;
   logic [2:0]      op_ff;
   logic            last_ff;

   assign out_free = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (emit.load) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
      if (emit.load) begin
         kind_ff    <= emit.kind;
         operand_ff <= emit.operand;
         op_ff      <= emit.op;
         last_ff    <= emit.last;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_out_operand = operand_ff;
   assign rsp_out_op      = op_ff;
   assign rsp_last        = last_ff;

endmodule

FILE: hdl/operator_precedence_postfix.sv
// top level of the operator precedence postfix converter
// Shunting-yard converter without parentheses: each request transaction is an
// operand handle, a shell operator or an end mark, and the response channel
// carries the postfix stream, with last set on the final response of each
// request. Operands go straight out; an operator first pops every stacked
// operator of equal or lower precedence level, then is pushed, or is dropped
// with an overflow response when the stack is full. The end mark flushes the
// stack and then sends an end response. The stack lives in a memory with
// registered read ports, and the sequencer pops one entry per cycle while the
// response register is free. A stalled response holds the sequencer in place.
// No clearing pass after reset.
`include "operator_precedence_postfix_assert.svh"

module operator_precedence_postfix
   import opp_pkg::*;
#(
   parameter int unsigned STACK_DEPTH = 16
) (
   input  logic            clock,
   input  logic            reset,
   // request channel
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [1:0]      req_mode,
   input  logic [ID_W-1:0] req_operand_id,
   input  logic [2:0]      req_op_code,
   // response channel
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [1:0]      rsp_kind,
   output logic [ID_W-1:0] rsp_out_operand,
   output logic [2:0]      rsp_out_op,
   output logic            rsp_last
);

   // address bits for the stack, count bits that can hold a full stack
   localparam int unsigned AW = $clog2(STACK_DEPTH);
   localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

   emit_type      emit;
   status_type    seq_status;
   logic          out_free;
   logic [CW-1:0] stack_count;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [2:0]    wr_data;
   logic [AW-1:0] rd0_addr;
   logic [AW-1:0] rd1_addr;
   logic [2:0]    rd0_data;
   logic [2:0]    rd1_data;
   logic          req_accept;

   // operator stack storage
   opp_stack #(
      .DEPTH (STACK_DEPTH),
      .AW    (AW)
   ) u_stack (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd0_addr (rd0_addr),
      .rd1_addr (rd1_addr),
      .rd0_data (rd0_data),
      .rd1_data (rd1_data)
   );

   // sequencer: compares the stack top against the incoming level
   opp_seq #(
      .DEPTH (STACK_DEPTH),
      .AW    (AW),
      .CW    (CW)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_operand_id (req_operand_id),
      .req_op_code    (req_op_code),
      .out_free       (out_free),
      .emit           (emit),
      .status         (seq_status),
      .count          (stack_count),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .rd0_addr       (rd0_addr),
      .rd1_addr       (rd1_addr),
      .rd0_data       (rd0_data),
      .rd1_data       (rd1_data)
   );

   // response register, decouples the sequencer from a stalling consumer
   opp_out u_out (
      .clock           (clock),
      .reset           (reset),
      .emit            (emit),
      .out_free        (out_free),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_out_operand (rsp_out_operand),
      .rsp_out_op      (rsp_out_op),
      .rsp_last        (rsp_last)
   );

   assign req_accept = req_valid && !req_stall;

   // stack never holds more than its depth
   `OPP_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, stack_count <= CW'(STACK_DEPTH))
   // no new transaction while the sequencer is walking the stack
   `OPP_ASSERT_IMPL(a_busy_stalls, clock, reset, seq_status.busy, req_stall)
   // an operand comes out on the next cycle as a single final response
   `OPP_ASSERT_NEXT(a_operand_pass, clock, reset, req_accept && (req_mode == MODE_OPERAND), rsp_valid && (rsp_kind == KIND_OPERAND) && rsp_last)
   // an end response only ever leaves behind an empty stack
   `OPP_ASSERT_IMPL(a_end_empty, clock, reset, rsp_valid && (rsp_kind == KIND_END), stack_count == '0)

endmodule
